### hdl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and types for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int NUM_FRAMES = 65536;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(MAP_WORDS);

  localparam int FRAME_W = 16;  // result_frame / start_frame
  localparam int CNT_W   = 17;  // frame_count, frame_limit, cursor
  localparam int POS_W   = 18;  // cursor + run, start + count

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [CNT_W-1:0] LIMIT_RST  = CNT_W'(65536);
  localparam logic [CNT_W-1:0] CURSOR_RST = CNT_W'(1);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               status;
  } rsp_t;

endpackage

### hdl/bfa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [FRAME_W-1:0] start_frame;
  logic [CNT_W-1:0]   frame_count;

  modport source (output valid, output opcode, output start_frame, output frame_count,
                  input ready);
  modport sink   (input valid, input opcode, input start_frame, input frame_count,
                  output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] result_frame;
  logic               status;

  modport source (output valid, output result_frame, output status, input ready);
  modport sink   (input valid, input result_frame, input status, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/bitmap_frame_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Next-fit page frame allocator over a one-bit-per-frame usage bitmap.
// ----------------------------------------------------------------------------
// Channels: req carries one operation (allocate, free range, mark range);
// rsp returns exactly one transaction per request (frame and status); cfg
// writes frame_limit, and is always ready. Write cfg only while idle.
// The bitmap lives in a 1024 x 64 RAM with registered read data.
// After reset the block sweeps all 1024 RAM words to zero, one word per
// cycle; req.ready stays low during that pass.
// Sequence: allocate scans in steps, where a step covers the rest of the
// current word, capped by the frames still needed and the room below the
// limit; on success it marks the run word by word, then goes to ST_FIN
// before rsp.valid. Free and mark go word by word over the range, and
// zero-length allocate and unknown opcodes go straight to ST_FIN. A scan
// step is a RAM read state (ST_AREAD) then an evaluate state (ST_AEVAL);
// a range word is a read (ST_RREAD) then a modify-write (ST_RWRITE).
// One request is in flight at a time; req.ready is high whenever the
// sequencer is idle, even with a response still waiting in the output
// register. If rsp is stalled, a finished request holds in the sequencer
// until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top import bfa_pkg::*; (
  input logic      clk,
  input logic      rst,
  bfa_cfg_if.sink  cfg,
  bfa_req_if.sink  req,
  bfa_rsp_if.source rsp
);

  logic [CNT_W-1:0]     frame_limit;
  logic                 out_free;
  logic                 done;
  rsp_t                 done_rsp;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RST;
    end else if (cfg.valid) begin
      frame_limit <= cfg.data;
    end
  end

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.result_frame <= done_rsp.frame;
      rsp.status       <= done_rsp.status;
    end
  end

  bfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .frame_limit (frame_limit),
    .out_free    (out_free),
    .done        (done),
    .done_rsp    (done_rsp),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  bfa_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### hdl/bfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/bfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clears the bitmap after reset, scans words for a free run, and
// does read-modify-write passes to set or clear frame ranges.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bfa_req_if.sink              req,
  input  logic [CNT_W-1:0]     frame_limit,
  input  logic                 out_free,
  output logic                 done,
  output rsp_t                 done_rsp,
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_waddr,
  output logic [WORD_BITS-1:0] ram_wdata,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [WORD_BITS-1:0] ram_rdata
);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_AREAD  = 3'd2;
  localparam logic [2:0] ST_AEVAL  = 3'd3;
  localparam logic [2:0] ST_RREAD  = 3'd4;
  localparam logic [2:0] ST_RWRITE = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  // bits lo..hi set
  function automatic logic [WORD_BITS-1:0] span_mask(input logic [OFF_W-1:0] lo,
                                                     input logic [OFF_W-1:0] hi);
    logic [OFF_W-1:0] top;
    top = OFF_W'(WORD_BITS - 1);
    return ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (top - hi));
  endfunction

  function automatic logic [OFF_W-1:0] top_bit(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) idx = OFF_W'(i);
    end
    return idx;
  endfunction

  // end of range, clipped to the map
  function automatic logic [POS_W-1:0] range_end(input logic [CNT_W-1:0] s,
                                                 input logic [CNT_W-1:0] n);
    logic [POS_W-1:0] e;
    e = POS_W'(s) + POS_W'(n);
    if (e > POS_W'(NUM_FRAMES)) e = POS_W'(NUM_FRAMES);
    return e;
  endfunction

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]  cursor;
  logic [CNT_W-1:0]  run;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  limit;
  logic [POS_W-1:0]  wpos;
  logic [POS_W-1:0]  wend;
  logic              set_bits;
  rsp_t              res;

  // allocate scan datapath
  logic [POS_W-1:0]     f;
  logic [OFF_W-1:0]     a_off;
  logic [POS_W-1:0]     room;
  logic [CNT_W-1:0]     need;
  logic [OFF_W:0]       avail;
  logic [OFF_W:0]       a_hi_w;
  logic [OFF_W-1:0]     a_hi;
  logic [WORD_BITS-1:0] a_used;
  logic [OFF_W-1:0]     a_top;
  logic [POS_W-1:0]     a_jump;
  logic [CNT_W-1:0]     a_run_after;
  logic [CNT_W-1:0]     a_run_sum;

  // range write datapath
  logic [POS_W-1:0]     r_last;
  logic [OFF_W-1:0]     r_hi;
  logic [WORD_BITS-1:0] r_mask;
  logic [POS_W-1:0]     r_next;

  always_comb begin
    f      = POS_W'(cursor) + POS_W'(run);
    a_off  = f[OFF_W-1:0];
    room   = POS_W'(limit) - f;
    need   = count - run;
    avail  = (OFF_W+1)'(WORD_BITS) - (OFF_W+1)'(a_off);
    if (need < CNT_W'(avail)) avail = need[OFF_W:0];
    if (room < POS_W'(avail)) avail = room[OFF_W:0];
    a_hi_w      = (OFF_W+1)'(a_off) + avail - (OFF_W+1)'(1);
    a_hi        = a_hi_w[OFF_W-1:0];
    a_used      = ram_rdata & span_mask(a_off, a_hi);
    a_top       = top_bit(a_used);
    a_jump      = {f[POS_W-1:OFF_W], a_top} + POS_W'(1);
    a_run_after = CNT_W'(a_hi - a_top);
    a_run_sum   = run + CNT_W'(avail);
  end

  always_comb begin
    r_last = wend - POS_W'(1);
    r_hi   = (r_last[POS_W-1:OFF_W] == wpos[POS_W-1:OFF_W]) ? r_last[OFF_W-1:0] : '1;
    r_mask = span_mask(wpos[OFF_W-1:0], r_hi);
    r_next = {wpos[POS_W-1:OFF_W], {OFF_W{1'b0}}} + POS_W'(WORD_BITS);
  end

  assign ram_we    = (state == ST_CLR) || (state == ST_RWRITE);
  assign ram_waddr = (state == ST_CLR) ? clr_addr : wpos[OFF_W +: ADDR_W];
  assign ram_wdata = (state == ST_CLR) ? '0 :
                     set_bits ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);
  assign ram_raddr = (state == ST_RREAD) ? wpos[OFF_W +: ADDR_W] : f[OFF_W +: ADDR_W];

  assign req.ready = (state == ST_IDLE);
  assign done      = (state == ST_FIN) && out_free;
  assign done_rsp  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      cursor   <= CURSOR_RST;
    end else begin
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MAP_WORDS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req.valid) begin
            count      <= req.frame_count;
            run        <= '0;
            res.frame  <= req.start_frame;
            res.status <= STATUS_OK;
            limit      <= (frame_limit > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES)
                                                             : frame_limit;
            case (req.opcode)
              OP_ALLOC: begin
                if (req.frame_count == '0) begin
                  res.frame <= cursor[FRAME_W-1:0];
                  state     <= ST_FIN;
                end else begin
                  state <= ST_AREAD;
                end
              end
              OP_FREE, OP_MARK: begin
                wpos     <= POS_W'(req.start_frame);
                wend     <= range_end(CNT_W'(req.start_frame), req.frame_count);
                set_bits <= (req.opcode == OP_MARK);
                state    <= ST_RREAD;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_AREAD: begin
          if (f >= POS_W'(limit)) begin
            res.frame  <= '0;
            res.status <= STATUS_FAIL;
            state      <= ST_FIN;
          end else begin
            state <= ST_AEVAL;
          end
        end
        ST_AEVAL: begin
          if (a_used != '0) begin
            // restart the run just past the last used frame in the window
            cursor <= a_jump[CNT_W-1:0];
            run    <= a_run_after;
            state  <= ST_AREAD;
          end else if (a_run_sum == count) begin
            res.frame <= cursor[FRAME_W-1:0];
            wpos      <= POS_W'(cursor);
            wend      <= range_end(cursor, count);
            set_bits  <= 1'b1;
            state     <= ST_RREAD;
          end else begin
            run   <= a_run_sum;
            state <= ST_AREAD;
          end
        end
        ST_RREAD: begin
          state <= (wpos >= wend) ? ST_FIN : ST_RWRITE;
        end
        ST_RWRITE: begin
          wpos  <= r_next;
          state <= ST_RREAD;
        end
        ST_FIN: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLR;
      endcase
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CNT_W'(NUM_FRAMES))
    else $error("search cursor beyond map");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RWRITE |-> wpos < wend)
    else $error("range write past its end");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> state == ST_CLR)
    else $error("bitmap clear pass skipped after reset");

  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_AEVAL |-> $past(state) == ST_AREAD)
    else $error("scan evaluated without a fresh word read");

  a_run_short: assert property (@(posedge clk) disable iff (rst)
    state == ST_AEVAL |-> run < count)
    else $error("scan run already complete");

endmodule

### dv/bitmap_frame_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_tb
// Self-checking bench for the next-fit bitmap frame allocator. A directed
// opening covers the corner cases, and randomized phases then run under
// several frame_limit settings. A scoreboard keeps its own copy of the
// bitmap, the cursor and the limit. It predicts every response and compares
// each one in order, with random idle cycles on both sides but in quiet phases.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top_tb;
  import bfa_pkg::*;

  localparam logic [1:0] OP_NONE   = 2'd3;    // undefined opcode, no-op
  localparam int         WDOG_MAX  = 600000;  // cycles with no transaction at all
  localparam int         MAX_LIMIT = 131071;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FRAME_W-1:0] start_frame;
    logic [CNT_W-1:0]   frame_count;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bfa_req_if req ();
  bfa_rsp_if rsp ();
  bfa_cfg_if cfg ();

  bitmap_frame_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // scoreboard state
  bit               frame_map [NUM_FRAMES];
  logic [CNT_W-1:0] scan_cursor   = CURSOR_RST;
  logic [CNT_W-1:0] frame_limit_q = LIMIT_RST;

  req_item_t   req_pending [$];
  rsp_t        predicted_rsp [$];
  int unsigned mismatch_count = 0;
  bit          quiet_phase = 1'b0;   // no idle cycles on either side
  int          req_gap;
  int          rsp_hold;
  int          idle_cycles;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void paint_range(int unsigned first, int unsigned count, bit used);
    int unsigned f;
    for (int unsigned i = 0; i < count; i++) begin
      f = first + i;
      if (f >= NUM_FRAMES)
        break;
      frame_map[f] = used;
    end
  endfunction

  function automatic rsp_t predict_op(req_item_t it);
    rsp_t        r;
    int unsigned lim;
    int unsigned run;
    int unsigned f;
    r.frame  = it.start_frame;
    r.status = STATUS_OK;
    case (it.opcode)
      OP_ALLOC: begin
        lim = (frame_limit_q > NUM_FRAMES) ? NUM_FRAMES : frame_limit_q;
        run = 0;
        while (run < it.frame_count) begin
          f = scan_cursor + run;
          if (f >= lim) begin
            r.status = STATUS_FAIL;
            break;
          end
          if (frame_map[f]) begin
            // restart the run just past the used frame
            scan_cursor = CNT_W'(f + 1);
            run = 0;
          end else begin
            run++;
          end
        end
        if (r.status == STATUS_FAIL) begin
          r.frame = '0;
        end else begin
          paint_range(scan_cursor, it.frame_count, 1'b1);
          r.frame = scan_cursor[FRAME_W-1:0];
        end
      end
      OP_FREE: paint_range(it.start_frame, it.frame_count, 1'b0);
      OP_MARK: paint_range(it.start_frame, it.frame_count, 1'b1);
      default: ;
    endcase
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin : req_driver
    req_item_t item;
    if (rst) begin
      req.valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req.valid && req.ready)
        predicted_rsp.push_back(predict_op({req.opcode, req.start_frame, req.frame_count}));
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap   <= req_gap - 1;
          req.valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          item            = req_pending.pop_front();
          req.opcode      <= item.opcode;
          req.start_frame <= item.start_frame;
          req.frame_count <= item.frame_count;
          req.valid       <= 1'b1;
          req_gap         <= quiet_phase ? 0 : $urandom_range(0, 4);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_hold  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (predicted_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected response frame=%0d status=%0b",
                                    rsp.result_frame, rsp.status));
        end else begin
          want = predicted_rsp.pop_front();
          if (rsp.result_frame !== want.frame)
            report_mismatch($sformatf("result_frame got %0d want %0d",
                                      rsp.result_frame, want.frame));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0b want %0b (frame %0d)",
                                      rsp.status, want.status, want.frame));
        end
        rsp_hold = quiet_phase ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold > 0) begin
        rsp.ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog: any transaction on any channel resets it
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic queue_op(logic [1:0] op, int unsigned first, int unsigned count);
    req_item_t it;
    it.opcode      = op;
    it.start_frame = FRAME_W'(first);
    it.frame_count = CNT_W'(count);
    while (req_pending.size() >= 2)
      @(posedge clk);
    req_pending.push_back(it);
  endtask

  // wait until the block has nothing in flight; checked at the falling edge
  // so the driver and monitor updates of the rising edge have settled
  task automatic drain();
    while (req_pending.size() != 0 || req.valid || predicted_rsp.size() != 0)
      @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned value);
    logic [CNT_W-1:0] v;
    v = CNT_W'(value);
    @(posedge clk);
    cfg.data  <= v;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready)
      @(posedge clk);
    cfg.valid     <= 1'b0;
    frame_limit_q = v;
  endtask

  initial begin
    int         pick;
    int         s;
    int         cnt;
    int         lim_val;
    logic [1:0] op;

    req.valid       = 1'b0;
    req.opcode      = OP_ALLOC;
    req.start_frame = '0;
    req.frame_count = '0;
    rsp.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.data        = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    write_limit(65536);
    queue_op(OP_ALLOC, 0, 0);            // zero length returns cursor
    queue_op(OP_ALLOC, 16'hFFFF, 1);
    queue_op(OP_ALLOC, 0, 1);            // cursor sits on a used frame
    queue_op(OP_MARK, 100, 50);
    queue_op(OP_ALLOC, 0, 200);          // scan skips the marked block
    queue_op(OP_FREE, 120, 10);
    queue_op(OP_FREE, 16'hFFFF, 65536);  // range runs past the map
    queue_op(OP_MARK, 16'hFFFF, 2);
    queue_op(OP_FREE, 16'hFFFF, 1);
    queue_op(OP_NONE, 16'hFFFF, MAX_LIMIT);
    queue_op(OP_NONE, 0, 0);
    queue_op(OP_MARK, 0, 0);
    queue_op(OP_FREE, 0, 0);
    queue_op(OP_MARK, 16'hFFFF, 0);
    queue_op(OP_ALLOC, 0, 65536);        // too long, fails at the limit
    queue_op(OP_ALLOC, 0, MAX_LIMIT);
    drain();
    write_limit(0);
    queue_op(OP_ALLOC, 0, 0);            // cursor already past the limit
    queue_op(OP_ALLOC, 0, 1);
    drain();
    write_limit(400);
    queue_op(OP_ALLOC, 0, 40);
    queue_op(OP_ALLOC, 0, 20);
    drain();
    write_limit(MAX_LIMIT);              // above the map, clamps to NUM_FRAMES
    queue_op(OP_ALLOC, 0, 5);
    queue_op(OP_FREE, 0, 8);
    drain();

    // randomized phases
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: lim_val = 65536;
        1: lim_val = MAX_LIMIT;
        2: lim_val = scan_cursor + $urandom_range(100, 4000);
        3: lim_val = 65535;
        4: lim_val = $urandom_range(0, MAX_LIMIT);
        5: lim_val = 65536;
        6: lim_val = 100000;
        default: lim_val = scan_cursor + $urandom_range(20, 600);
      endcase
      if (lim_val > MAX_LIMIT)
        lim_val = MAX_LIMIT;
      write_limit(lim_val);
      quiet_phase = (p == 1 || p == 5);

      for (int k = 0; k < 210; k++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OP_ALLOC : (pick < 70) ? OP_FREE : (pick < 95) ? OP_MARK : OP_NONE;

        // keep most ranges around the cursor, where the scan happens
        if ($urandom_range(0, 9) < 7) begin
          s = int'(scan_cursor) - 500 + int'($urandom_range(0, 1500));
          if (s < 0)
            s = 0;
          if (s > 65535)
            s = 65535;
        end else begin
          s = $urandom_range(0, 65535);
        end

        pick = $urandom_range(0, 99);
        if (op == OP_ALLOC) begin
          if (pick < 5)       cnt = 0;
          else if (pick < 80) cnt = $urandom_range(1, 16);
          else if (pick < 96) cnt = $urandom_range(17, 400);
          else                cnt = $urandom_range(0, MAX_LIMIT);
        end else if (op == OP_NONE) begin
          cnt = $urandom_range(0, MAX_LIMIT);
        end else begin
          if (pick < 5)       cnt = 0;
          else if (pick < 85) cnt = $urandom_range(1, 128);
          else if (pick < 97) cnt = $urandom_range(129, 2048);
          else                cnt = $urandom_range(0, MAX_LIMIT);
        end

        queue_op(op, s, cnt);
        // a huge mark is trimmed right away so the cursor is not pushed to the end
        if (op == OP_MARK && cnt > 2048)
          queue_op(OP_FREE, s + $urandom_range(1, 64), MAX_LIMIT);
      end
      drain();
    end

    // closing case: full map drives the cursor to the top of the map
    quiet_phase = 1'b0;
    write_limit(65536);
    queue_op(OP_MARK, 0, 65536);
    queue_op(OP_ALLOC, 0, 1);
    queue_op(OP_ALLOC, 16'hFFFF, 0);     // cursor 65536 comes back as 0
    queue_op(OP_FREE, 0, 65536);
    queue_op(OP_ALLOC, 0, 3);
    drain();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && predicted_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
